// ----- sv/gcbr_pkg.sv -----
package gcbr_pkg;

  localparam logic [2:0] MODE_MEAN  = 3'd0;
  localparam logic [2:0] MODE_FIRST = 3'd1;
  localparam logic [2:0] MODE_LAST  = 3'd2;
  localparam logic [2:0] MODE_MIN   = 3'd3;
  localparam logic [2:0] MODE_MAX   = 3'd4;
  localparam logic [2:0] MODE_RMS   = 3'd5;
  localparam logic [2:0] MODE_SUM   = 3'd6;
  localparam logic [2:0] MODE_COUNT = 3'd7;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_NODATA = 2'd1;
  localparam logic [1:0] REG_COLS   = 2'd2;
  localparam logic [1:0] REG_ROWS   = 2'd3;

  localparam logic       KIND_POINT = 1'b0;
  localparam logic       KIND_READ  = 1'b1;

  localparam int         ACC_W  = 64;
  localparam int         HITS_W = 16;

endpackage

// ----- sv/grid_cell_binning_reducer.sv -----
// Grid cell binning reducer. Point items (kind 0) fold a Q16.16 sample into one
// cell of a grid held in a synchronous memory of MAX_COLUMNS*MAX_ROWS words
// (64-bit accumulator and 16-bit hit count), with one read port and one write
// port; read items (kind 1) finalize a cell, return one result transfer and
// clear the cell. A point does the memory read in the accept cycle and the
// write-back in the next. A read of an empty cell or in first, last, min, max,
// sum or count mode passes through the memory read, the write-back and a finish
// step; mean adds the bit-serial divider and rms adds the divider followed by
// the bit-serial square root. A read also waits for as long as a previous
// result is held by out_stall. Indices of -1 or exactly the grid size are
// clamped to the edge cell; other out-of-range items are accepted and dropped.
// After reset a clearing pass zeroes all MAX_COLUMNS*MAX_ROWS memory words
// while in_stall stays high; configuration writes are taken meanwhile.
module grid_cell_binning_reducer
  import gcbr_pkg::*;
#(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  column,
  input  logic [7:0]  row,
  input  logic [31:0] sample_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] cell_result,
  output logic [15:0] hit_count,
  output logic        cell_empty,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int WW    = ACC_W + HITS_W;

  typedef enum logic [2:0] {IDLE, MODIFY, DIVIDE, ROOT, FINISH} state_t;

  function automatic logic [11:0] map_idx(input logic [7:0] idx, input logic [10:0] lim);
    logic [10:0] ix;
    ix = {{3{idx[7]}}, idx};
    if (idx == 8'hFF) return {1'b1, 11'd0};
    if (!idx[7] && ix == lim) return {1'b1, lim - 11'd1};
    if (idx[7] || ix > lim) return {1'b0, 11'd0};
    return {1'b1, ix};
  endfunction

  function automatic logic [31:0] sat32(input logic [63:0] v);
    if (v[63:31] == {33{1'b0}} || v[63:31] == {33{1'b1}}) return v[31:0];
    return v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  // Configuration registers.
  logic [2:0]  reduce_mode;
  logic [31:0] empty_value;
  logic [6:0]  grid_columns;
  logic [6:0]  grid_rows;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_mode  <= MODE_MEAN;
      empty_value  <= 32'h8000_0000;
      grid_columns <= 7'd64;
      grid_rows    <= 7'd64;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_MODE:   reduce_mode  <= pwdata[2:0];
        REG_NODATA: empty_value  <= pwdata;
        REG_COLS:   grid_columns <= pwdata[6:0];
        REG_ROWS:   grid_rows    <= pwdata[6:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:   prdata = {29'd0, reduce_mode};
      REG_NODATA: prdata = empty_value;
      REG_COLS:   prdata = {25'd0, grid_columns};
      REG_ROWS:   prdata = {25'd0, grid_rows};
      default:    prdata = '0;
    endcase
  end

  // Index mapping.
  logic [10:0] col_lim, row_lim;
  logic [11:0] col_map, row_map;
  logic [AW-1:0] in_addr;

  always_comb begin
    if (grid_columns == 7'd0) col_lim = 11'd1;
    else if (11'(grid_columns) > 11'(MAX_COLUMNS)) col_lim = 11'(MAX_COLUMNS);
    else col_lim = 11'(grid_columns);
    if (grid_rows == 7'd0) row_lim = 11'd1;
    else if (11'(grid_rows) > 11'(MAX_ROWS)) row_lim = 11'(MAX_ROWS);
    else row_lim = 11'(grid_rows);
    col_map = map_idx(column, col_lim);
    row_map = map_idx(row, row_lim);
    in_addr = AW'(32'(row_map[10:0]) * MAX_COLUMNS + 32'(col_map[10:0]));
  end

  // Cell memory.
  logic [WW-1:0] mem [CELLS];
  logic [WW-1:0] rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [WW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[in_addr];
  end

  // Control and datapath registers.
  state_t        state;
  logic          clearing;
  logic [AW-1:0] clr_cnt;
  logic          item_kind;
  logic [31:0]   sample;
  logic [AW-1:0] addr;
  logic [15:0]   rhits;
  logic          rempty;
  logic [63:0]   res;
  logic [63:0]   dvd;
  logic [15:0]   rem;
  logic          neg;
  logic [5:0]    cnt;
  logic [63:0]   sx, sres, sbit;

  logic [63:0] acc;
  logic [15:0] hits;
  logic [63:0] sv64;
  logic [31:0] mag;
  logic [63:0] sq;
  logic [64:0] usum;
  logic [64:0] ssum;
  logic [63:0] acc_next;
  logic [15:0] hits_next;
  logic [16:0] rsh;
  logic        qbit;
  logic [63:0] strial;
  logic        take;

  assign in_stall = clearing || (state != IDLE);
  assign take     = in_valid && !in_stall && col_map[11] && row_map[11];

  always_comb begin
    acc  = rdata[ACC_W-1:0];
    hits = rdata[WW-1:ACC_W];
    sv64 = {{32{sample[31]}}, sample};
    mag  = sample[31] ? 32'(-sample) : sample;
    sq   = mag * mag;
    usum = {1'b0, acc} + {1'b0, sq};
    ssum = {acc[63], acc} + {sv64[63], sv64};
    case (reduce_mode)
      MODE_FIRST: acc_next = (hits == 16'd0) ? sv64 : acc;
      MODE_LAST:  acc_next = sv64;
      MODE_MIN:   acc_next = (hits == 16'd0 || $signed(sv64) < $signed(acc)) ? sv64 : acc;
      MODE_MAX:   acc_next = (hits == 16'd0 || $signed(sv64) > $signed(acc)) ? sv64 : acc;
      MODE_RMS:   acc_next = usum[64] ? {64{1'b1}} : usum[63:0];
      default: begin
        if (ssum[64] != ssum[63])
          acc_next = ssum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
          acc_next = ssum[63:0];
      end
    endcase
    hits_next = (hits == 16'hFFFF) ? hits : hits + 16'd1;

    rsh    = {rem, dvd[63]};
    qbit   = rsh >= {1'b0, rhits};
    strial = sres + sbit;

    we    = 1'b0;
    waddr = addr;
    wdata = '0;
    if (clearing) begin
      we    = 1'b1;
      waddr = clr_cnt;
    end else if (state == MODIFY) begin
      we = 1'b1;
      if (item_kind == KIND_POINT) wdata = {hits_next, acc_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + AW'(1);
        if (clr_cnt == AW'(CELLS - 1)) clearing <= 1'b0;
      end
      if (out_valid && !out_stall && state != FINISH) out_valid <= 1'b0;

      unique case (state)
        IDLE: begin
          if (take) begin
            item_kind <= kind;
            sample    <= sample_value;
            addr      <= in_addr;
            state     <= MODIFY;
          end
        end
        MODIFY: begin
          rhits  <= hits;
          rempty <= (hits == 16'd0);
          if (item_kind == KIND_POINT) begin
            state <= IDLE;
          end else if (hits == 16'd0) begin
            res   <= {{32{empty_value[31]}}, empty_value};
            state <= FINISH;
          end else begin
            // For mean, divide the magnitude and restore the sign, which truncates toward zero.
            neg <= (reduce_mode == MODE_MEAN) && acc[63];
            dvd <= ((reduce_mode == MODE_MEAN) && acc[63]) ? -acc : acc;
            rem <= '0;
            cnt <= 6'd63;
            case (reduce_mode)
              MODE_MEAN: state <= DIVIDE;
              MODE_RMS:  state <= DIVIDE;
              MODE_COUNT: begin
                res   <= {32'd0, hits, 16'd0};
                state <= FINISH;
              end
              default: begin
                res   <= acc;
                state <= FINISH;
              end
            endcase
          end
        end
        DIVIDE: begin
          rem <= qbit ? 16'(rsh - {1'b0, rhits}) : rsh[15:0];
          dvd <= {dvd[62:0], qbit};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            if (reduce_mode == MODE_RMS) begin
              sx    <= {dvd[62:0], qbit};
              sres  <= '0;
              sbit  <= {2'b01, 62'd0};
              state <= ROOT;
            end else begin
              res   <= neg ? -{dvd[62:0], qbit} : {dvd[62:0], qbit};
              state <= FINISH;
            end
          end
        end
        ROOT: begin
          if (sx >= strial) begin
            sx   <= sx - strial;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          if (sbit[0]) begin
            res   <= (sx >= strial) ? (sres >> 1) + sbit : sres >> 1;
            state <= FINISH;
          end
        end
        FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            cell_result <= sat32(res);
            hit_count   <= rhits;
            cell_empty  <= rempty;
            state       <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- sv/gcbr_checker.sv -----
module gcbr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        kind,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] cell_result,
  input logic [15:0] hit_count,
  input logic        cell_empty
);

  // A waiting result holds until its transfer completes.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cell_result) && $stable(hit_count))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // The clearing pass holds off input right after reset.
  a_reset_busy: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input open during clearing");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && cell_empty |-> hit_count == 16'd0)
    else $error("empty cell with nonzero count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cell_empty |-> hit_count != 16'd0)
    else $error("filled cell with zero count");

endmodule

bind grid_cell_binning_reducer gcbr_checker u_gcbr_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
  .out_valid(out_valid), .out_stall(out_stall), .cell_result(cell_result),
  .hit_count(hit_count), .cell_empty(cell_empty)
);

// ----- tb/tb_grid_cell_binning_reducer.sv -----
module tb_grid_cell_binning_reducer;
  import gcbr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCOLS      = 64;
  localparam int NROWS      = 64;
  localparam int NCELLS     = NCOLS * NROWS;
  localparam int DRAIN_WAIT = 150;
  localparam int CYCLE_CAP  = 3000000;
  localparam int NPHASES    = 14;
  localparam int PHASE_LEN  = 128;

  typedef struct {
    logic [31:0] value;
    logic [15:0] hits;
    logic        empty;
  } cell_out_t;

  typedef struct {
    logic        kind;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [31:0] value;
    bit          typed;
    cell_out_t   want;
  } bin_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = KIND_POINT;
  logic [7:0]  column = '0;
  logic [7:0]  row = '0;
  logic [31:0] sample_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] cell_result;
  logic [15:0] hit_count;
  logic        cell_empty;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  grid_cell_binning_reducer DUT (.*);

  always #5 clk = ~clk;

  // Shadow copy of the grid store and registers.
  logic [63:0] cell_sum [NCELLS];
  logic [15:0] cell_cnt [NCELLS];
  logic [2:0]  cur_mode;
  logic [31:0] cur_nodata;
  logic [6:0]  cur_cols;
  logic [6:0]  cur_rows;

  cell_out_t   pending_cells[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          items_sent = 0;
  int          reads_done = 0;
  int          quiet = 0;
  int          stall_hold = 0;
  int          stall_pct = 30;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] clip32(longint signed v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Returns the cell coordinate, or -1 when the index falls outside the grid.
  function automatic int map_edge(logic [7:0] idx, logic [6:0] size, int maxv);
    int lim;
    int i;
    lim = (size == 0) ? 1 : ((size > maxv) ? maxv : size);
    i = $signed(idx);
    if (i == -1) return 0;
    if (i == lim) return lim - 1;
    if (i < 0 || i > lim) return -1;
    return i;
  endfunction

  task automatic bin_item(input logic k, input logic [7:0] c, input logic [7:0] r,
                          input logic [31:0] v, output bit has_out, output cell_out_t o);
    int          ci;
    int          ri;
    int          idx;
    logic [63:0] a;
    logic [15:0] h;
    longint signed sv;
    longint signed res;
    logic [63:0] sq;
    logic [64:0] usum;
    logic signed [64:0] ssum;
    has_out = 0;
    o = '{default: '0};
    ci = map_edge(c, cur_cols, NCOLS);
    ri = map_edge(r, cur_rows, NROWS);
    if (ci < 0 || ri < 0) return;
    idx = ri * NCOLS + ci;
    a = cell_sum[idx];
    h = cell_cnt[idx];
    sv = $signed(v);
    if (k == KIND_POINT) begin
      case (cur_mode)
        MODE_FIRST: if (h == 0) a = sv;
        MODE_LAST:  a = sv;
        MODE_MIN:   if (h == 0 || sv < $signed(a)) a = sv;
        MODE_MAX:   if (h == 0 || sv > $signed(a)) a = sv;
        MODE_RMS: begin
          sq = (sv < 0) ? -sv : sv;
          sq = sq * sq;
          usum = {1'b0, a} + {1'b0, sq};
          a = usum[64] ? '1 : usum[63:0];
        end
        default: begin
          ssum = $signed({a[63], a}) + $signed({{33{v[31]}}, v});
          if (ssum[64] != ssum[63]) a = ssum[64] ? 64'h8000000000000000 : 64'h7fffffffffffffff;
          else a = ssum[63:0];
        end
      endcase
      cell_sum[idx] = a;
      if (h != 16'hffff) cell_cnt[idx] = h + 16'd1;
      return;
    end
    has_out = 1;
    if (h == 0) begin
      o = '{cur_nodata, 16'd0, 1'b1};
    end else begin
      case (cur_mode)
        MODE_MEAN:  res = $signed(a) / longint'(h);
        MODE_RMS:   res = int_sqrt(a / {48'd0, h});
        MODE_COUNT: res = longint'(h) * 65536;
        default:    res = $signed(a);
      endcase
      o = '{clip32(res), h, 1'b0};
    end
    cell_sum[idx] = '0;
    cell_cnt[idx] = '0;
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_MODE:   cur_mode = data[2:0];
      REG_NODATA: cur_nodata = data;
      REG_COLS:   cur_cols = data[6:0];
      default:    cur_rows = data[6:0];
    endcase
  endtask

  // Sends one item; the valid line stays high afterward so back-to-back
  // transfers need no drop.
  task automatic send_item(input logic k, input logic [7:0] c, input logic [7:0] r,
                           input logic [31:0] v, input bit typed, input cell_out_t want);
    int        gap;
    int        pick;
    bit        has_out;
    cell_out_t o;
    pick = $urandom_range(0, 99);
    gap = (quiet != 0 || pick < 60) ? 0 : (pick < 92 ? $urandom_range(1, 3)
                                                     : $urandom_range(10, 40));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k; column <= c; row <= r; sample_value <= v;
    do @(posedge clk); while (in_stall);
    items_sent++;
    bin_item(k, c, r, v, has_out, o);
    if (has_out) pending_cells.push_back(typed ? want : o);
  endtask

  task automatic settle;
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_index(logic [6:0] size, int maxv);
    int lim;
    int p;
    lim = (size == 0) ? 1 : ((size > maxv) ? maxv : size);
    p = $urandom_range(0, 99);
    if (p < 8) return 8'hff;
    if (p < 16) return 8'(lim);
    if (p < 60) return 8'($urandom_range(0, (lim < 4) ? lim - 1 : 3));
    return 8'($urandom_range(0, lim - 1));
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? $urandom_range(0, 300000) : -$urandom_range(0, 300000);
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (quiet != 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      stall_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    cell_out_t w;
    if (!rst && out_valid && !out_stall) begin
      reads_done++;
      if (pending_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected cell transfer: result %h hits %0d empty %b",
                   cell_result, hit_count, cell_empty);
      end else begin
        w = pending_cells.pop_front();
        if (w.value !== cell_result || w.hits !== hit_count || w.empty !== cell_empty) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cell mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                     w.value, w.hits, w.empty, cell_result, hit_count, cell_empty);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("grid_cell_binning_reducer regression: fail");
      $finish;
    end
  end

  bin_row_t  plan[$];
  cell_out_t none;

  initial begin
    int          n;
    bit          rd;
    logic [31:0] cfg;
    none = '{default: '0};
    for (int i = 0; i < NCELLS; i++) begin
      cell_sum[i] = '0;
      cell_cnt[i] = '0;
    end
    cur_mode = MODE_MEAN;
    cur_nodata = 32'h80000000;
    cur_cols = 7'd64;
    cur_rows = 7'd64;

    // Rows under the reset configuration (mean, 64 by 64).
    plan = '{
      '{KIND_READ,  8'd0,   8'd0,   32'h0,        1, '{32'h80000000, 16'd0, 1'b1}},
      '{KIND_POINT, 8'hff,  8'hff,  32'h7fffffff, 0, none},
      '{KIND_POINT, 8'd64,  8'd64,  32'h80000000, 0, none},
      '{KIND_POINT, 8'd0,   8'd0,   32'h7fffffff, 0, none},
      '{KIND_READ,  8'd0,   8'd0,   32'h0,        1, '{32'h7fffffff, 16'd2, 1'b0}},
      '{KIND_READ,  8'd63,  8'd63,  32'h0,        1, '{32'h80000000, 16'd1, 1'b0}},
      '{KIND_POINT, 8'd65,  8'd0,   32'h12345678, 0, none},
      '{KIND_POINT, 8'hfe,  8'd3,   32'h1,        0, none},
      '{KIND_POINT, 8'h80,  8'h7f,  32'h1,        0, none},
      '{KIND_READ,  8'd65,  8'd0,   32'h0,        0, none},
      '{KIND_READ,  8'd0,   8'hfe,  32'h0,        0, none},
      '{KIND_POINT, 8'd5,   8'd7,   32'h00030000, 0, none},
      '{KIND_POINT, 8'd5,   8'd7,   32'hfffe0000, 0, none},
      '{KIND_POINT, 8'd5,   8'd7,   32'h00008000, 0, none},
      '{KIND_READ,  8'd5,   8'd7,   32'hffffffff, 0, none},
      '{KIND_READ,  8'd5,   8'd7,   32'h0,        1, '{32'h80000000, 16'd0, 1'b1}},
      '{KIND_POINT, 8'd63,  8'd0,   32'hffffffff, 0, none},
      '{KIND_READ,  8'd64,  8'hff,  32'h0,        0, none}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    quiet = 1;
    foreach (plan[i]) send_item(plan[i].kind, plan[i].col, plan[i].row, plan[i].value,
                                plan[i].typed, plan[i].want);
    settle();

    for (int ph = 0; ph < NPHASES; ph++) begin
      quiet = (ph % 5 == 2);
      stall_pct = (ph % 3) * 25;
      reg_write(REG_MODE, (ph < 8) ? ph : $urandom_range(0, 7));
      case (ph % 4)
        0: cfg = 32'h80000000;
        1: cfg = 32'h7fffffff;
        default: cfg = $urandom();
      endcase
      reg_write(REG_NODATA, cfg);
      case (ph % 6)
        0: cfg = 64;
        1: cfg = 1;
        2: cfg = 0;
        3: cfg = 127;
        default: cfg = $urandom_range(2, 63);
      endcase
      reg_write(REG_COLS, cfg);
      reg_write(REG_ROWS, (ph % 5 == 1) ? 1 : ((ph % 7 == 3) ? 100 : $urandom_range(1, 64)));
      n = 0;
      while (n < PHASE_LEN) begin
        rd = ($urandom_range(0, 99) < 25);
        if ($urandom_range(0, 9) == 0)
          send_item(rd, 8'($urandom()), 8'($urandom()), $urandom(), 0, none);
        else
          send_item(rd, pick_index(cur_cols, NCOLS), pick_index(cur_rows, NROWS),
                    pick_sample(), 0, none);
        n++;
      end
      settle();
    end

    $display("%0d items sent over %0d register settings, %0d cell reads returned",
             items_sent, NPHASES + 1, reads_done);
    if (mismatches == 0) begin
      $display("grid_cell_binning_reducer regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("grid_cell_binning_reducer regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/gcbr_pkg.sv
sv/grid_cell_binning_reducer.sv
sv/gcbr_checker.sv
tb/tb_grid_cell_binning_reducer.sv
